// ----- hdl/dlmd_pkg.sv -----
// Shared types and constants for the distance limited motor drive.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dlmd_pkg;

  // Drive geometry and fixed output levels.
  localparam logic [7:0] MOTOR_STEPS  = 8'd10;
  localparam logic [7:0] STEER_STEPS  = 8'd10;
  localparam logic [7:0] SERVO_MIDDLE = 8'd90;
  localparam logic [7:0] SERVO_MIN    = 8'd45;
  localparam logic [7:0] SERVO_MAX    = 8'd135;
  localparam logic [7:0] LIGHT_DUTY   = 8'd128;

  // Register reset values.
  localparam logic [7:0]  DIST_LOWER_RST     = 8'd20;
  localparam logic [7:0]  DIST_UPPER_RST     = 8'd80;
  localparam logic [15:0] LIMIT_SLOPE_RST    = 16'd3;
  localparam logic [15:0] LIMIT_OFFSET_RST   = 16'd0;
  localparam logic [15:0] SPEED_PER_STEP_RST = 16'd2560;
  localparam logic [7:0]  START_DUTY_RST     = 8'd100;
  localparam logic [7:0]  MAX_DUTY_RST       = 8'd255;
  localparam logic [15:0] STEER_PER_STEP_RST = 16'd2048;

  // Stream word widths.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIST_LOWER     = 3'd0,
    REG_DIST_UPPER     = 3'd1,
    REG_LIMIT_SLOPE    = 3'd2,
    REG_LIMIT_OFFSET   = 3'd3,
    REG_SPEED_PER_STEP = 3'd4,
    REG_START_DUTY     = 3'd5,
    REG_MAX_DUTY       = 3'd6,
    REG_STEER_PER_STEP = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    KIND_DIST  = 1'b0,
    KIND_DRIVE = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic [7:0]         dist_lower;
    logic [7:0]         dist_upper;
    logic signed [15:0] limit_slope;
    logic signed [15:0] limit_offset;
    logic [15:0]        speed_per_step;
    logic [7:0]         start_duty;
    logic [7:0]         max_duty;
    logic [15:0]        steer_per_step;
  } cfg_t;

  // One classified word as it travels through the queue. The steering
  // step is already forced to zero when it lies outside -STEER_STEPS to STEER_STEPS.
  typedef struct packed {
    item_kind_t        kind;
    logic [7:0]        dist_front;
    logic [7:0]        dist_back;
    logic              direction;
    logic signed [7:0] speed_step;
    logic signed [7:0] steer_step;
    logic              light_on;
    logic              failsafe_on;
  } word_t;

  typedef struct packed {
    logic [7:0] light_duty;
    logic [7:0] servo_angle;
    logic       stopped;
    logic       drive_rev;
    logic       drive_fwd;
    logic [7:0] motor_duty;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/distance_limited_motor_drive.sv -----
// Top level of the distance limited motor drive: register file, front,
// queue and back parts. Depends on dlmd_pkg, dlmd_front, dlmd_queue and dlmd_back.
//
// A word with tuser 0 carries front and back range readings and updates
// the per-side step limit and duty-per-step scale; it gives no output word.
// A word with tuser 1 is a drive command and gives exactly one output word
// with the motor duty, bridge pins, stop flag, servo angle and light duty.
// The back sequencer steps through fetch, multiply, then scale update or
// result for each word and takes no new word until it is back in idle; the
// front register and the two-entry queue keep accepting words while a
// result waits on the output, until the queue is full. Registers are
// written through cfg_we/cfg_index/cfg_data and should only change while
// the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module distance_limited_motor_drive
  import dlmd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // dist_front[7:0], dist_back[15:8], direction[16], speed_step[24:17],
  // steer_step[32:25], light_on[33], failsafe_on[34], zero fill above
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // command[0]
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // motor_duty[7:0], drive_fwd[8], drive_rev[9], stopped[10],
  // servo_angle[18:11], light_duty[26:19], zero fill above
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  word_t   front_word;
  logic    front_valid;
  logic    front_ready;
  word_t   back_word;
  logic    back_valid;
  logic    back_ready;
  result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dist_lower     <= DIST_LOWER_RST;
      cfg.dist_upper     <= DIST_UPPER_RST;
      cfg.limit_slope    <= $signed(LIMIT_SLOPE_RST);
      cfg.limit_offset   <= $signed(LIMIT_OFFSET_RST);
      cfg.speed_per_step <= SPEED_PER_STEP_RST;
      cfg.start_duty     <= START_DUTY_RST;
      cfg.max_duty       <= MAX_DUTY_RST;
      cfg.steer_per_step <= STEER_PER_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DIST_LOWER:     cfg.dist_lower     <= cfg_data[7:0];
        REG_DIST_UPPER:     cfg.dist_upper     <= cfg_data[7:0];
        REG_LIMIT_SLOPE:    cfg.limit_slope    <= $signed(cfg_data);
        REG_LIMIT_OFFSET:   cfg.limit_offset   <= $signed(cfg_data);
        REG_SPEED_PER_STEP: cfg.speed_per_step <= cfg_data;
        REG_START_DUTY:     cfg.start_duty     <= cfg_data[7:0];
        REG_MAX_DUTY:       cfg.max_duty       <= cfg_data[7:0];
        REG_STEER_PER_STEP: cfg.steer_per_step <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dlmd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .in_kind   (s_axis_tuser),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_word  (front_word)
  );

  dlmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_word  (front_word),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_word   (back_word)
  );

  dlmd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (back_valid),
    .in_ready   (back_ready),
    .in_word    (back_word),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (result)
  );

  assign m_axis_tdata = {5'd0, result};

endmodule

`default_nettype wire

// ----- hdl/dlmd_front.sv -----
// Input side: accepts stream words, unpacks and classifies them.
// Depends on dlmd_pkg; feeds dlmd_queue.
`timescale 1ns / 1ps
`default_nettype none

module dlmd_front
  import dlmd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [IN_DATA_W-1:0] in_data,
  input  wire logic                 in_kind,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output word_t                     out_word
);

  word_t             held;
  logic              held_valid;
  word_t             decoded;
  logic signed [7:0] steer_raw;
  logic signed [7:0] steer_lim;
  logic              steer_ok;

  assign steer_raw = $signed(in_data[32:25]);
  assign steer_lim = $signed(STEER_STEPS);
  assign steer_ok  = (steer_raw <= steer_lim) && (steer_raw >= -steer_lim);

  always_comb begin
    decoded.kind        = item_kind_t'(in_kind);
    decoded.dist_front  = in_data[7:0];
    decoded.dist_back   = in_data[15:8];
    decoded.direction   = in_data[16];
    decoded.speed_step  = $signed(in_data[24:17]);
    decoded.steer_step  = steer_ok ? steer_raw : 8'sd0;
    decoded.light_on    = in_data[33];
    decoded.failsafe_on = in_data[34];
  end

  assign in_ready  = !held_valid || out_ready;
  assign out_valid = held_valid;
  assign out_word  = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (out_ready) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= decoded;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/dlmd_queue.sv -----
// Two-entry queue of classified words between the front and back parts.
// Depends on dlmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dlmd_queue
  import dlmd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire word_t push_word,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output word_t      pop_word
);

  word_t               mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = count != (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_word   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_word;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/dlmd_back.sv -----
// Execution side: updates the per-side limits from range readings and
// turns drive words into motor, servo and light settings.
// Depends on dlmd_pkg; takes words from dlmd_queue.
`timescale 1ns / 1ps
`default_nettype none

module dlmd_back
  import dlmd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire word_t in_word,
  output logic       out_valid,
  input  wire logic  out_ready,
  output result_t    out_result
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MUL   = 4'b0010,
    ST_SCALE = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t  state;
  word_t   cur;
  result_t res;
  logic    res_valid;

  logic [7:0]  front_step_limit;
  logic [7:0]  back_step_limit;
  logic [15:0] front_speed_scale;
  logic [15:0] back_speed_scale;

  // Products held between the multiply cycle and the scale or output cycle.
  logic signed [25:0] f_front;
  logic signed [25:0] f_back;
  logic               close_front;
  logic               far_front;
  logic               close_back;
  logic               far_back;
  logic [22:0]        duty_prod;
  logic               step_ok;
  logic signed [25:0] steer_prod;

  // Multiply cycle, distance words.
  logic signed [25:0] f_front_next;
  logic signed [25:0] f_back_next;

  assign f_front_next = $signed({1'b0, cur.dist_front}) * $signed(cfg.limit_slope)
                        + $signed(cfg.limit_offset);
  assign f_back_next  = $signed({1'b0, cur.dist_back}) * $signed(cfg.limit_slope)
                        + $signed(cfg.limit_offset);

  // Multiply cycle, drive words.
  logic [7:0]        lim_sel;
  logic [15:0]       scale_sel;
  logic signed [8:0] step_req;
  logic signed [8:0] step_eff;
  logic              step_ok_next;

  always_comb begin
    lim_sel  = cur.direction ? back_step_limit : front_step_limit;
    step_req = $signed({cur.speed_step[7], cur.speed_step});
    step_eff = step_req;
    scale_sel = cfg.speed_per_step;
    if (cur.failsafe_on) begin
      if ($signed({1'b0, lim_sel}) < step_req) begin
        step_eff = $signed({1'b0, lim_sel});
      end
      scale_sel = cur.direction ? back_speed_scale : front_speed_scale;
    end
    step_ok_next = (step_eff >= 9'sd1) && (step_eff <= $signed({1'b0, MOTOR_STEPS}));
  end

  // Scale cycle: duty per step inside the limited band, rounded and saturated.
  logic [39:0] sprod_front;
  logic [39:0] sprod_back;
  logic [15:0] scale_front_next;
  logic [15:0] scale_back_next;

  assign sprod_front = {24'd0, cfg.speed_per_step} * {17'd0, f_front[22:0]} + 40'd128;
  assign sprod_back  = {24'd0, cfg.speed_per_step} * {17'd0, f_back[22:0]} + 40'd128;

  always_comb begin
    if (close_front || far_front) begin
      scale_front_next = cfg.speed_per_step;
    end else if (f_front <= 26'sd0) begin
      scale_front_next = 16'd0;
    end else if (sprod_front[39:24] != 16'd0) begin
      scale_front_next = 16'hFFFF;
    end else begin
      scale_front_next = sprod_front[23:8];
    end
    if (close_back || far_back) begin
      scale_back_next = cfg.speed_per_step;
    end else if (f_back <= 26'sd0) begin
      scale_back_next = 16'd0;
    end else if (sprod_back[39:24] != 16'd0) begin
      scale_back_next = 16'hFFFF;
    end else begin
      scale_back_next = sprod_back[23:8];
    end
  end

  // Output cycle: motor duty and servo angle.
  logic [23:0]        duty_round;
  logic [16:0]        duty_sum;
  logic               running;
  logic signed [25:0] steer_total;
  logic [25:0]        steer_mag;
  logic [25:0]        mag_round;
  logic signed [18:0] angle_full;
  logic signed [18:0] angle_clamp;
  result_t            res_next;

  always_comb begin
    duty_round  = {1'b0, duty_prod} + 24'd128;
    duty_sum    = {9'd0, cfg.start_duty} + {1'b0, duty_round[23:8]};
    running     = step_ok && (duty_sum <= {9'd0, cfg.max_duty});

    steer_total = steer_prod + $signed({10'd0, SERVO_MIDDLE, 8'd0});
    steer_mag   = steer_total[25] ? 26'(-steer_total) : steer_total;
    mag_round   = steer_mag + 26'd128;
    angle_full  = steer_total[25] ? -$signed({1'b0, mag_round[25:8]})
                                  : $signed({1'b0, mag_round[25:8]});
    angle_clamp = angle_full;
    if (angle_clamp > $signed({11'd0, SERVO_MAX})) begin
      angle_clamp = $signed({11'd0, SERVO_MAX});
    end
    if (angle_clamp < $signed({11'd0, SERVO_MIN})) begin
      angle_clamp = $signed({11'd0, SERVO_MIN});
    end

    res_next.motor_duty  = running ? duty_sum[7:0] : 8'd0;
    res_next.drive_fwd   = running && !cur.direction;
    res_next.drive_rev   = running && cur.direction;
    res_next.stopped     = !running;
    res_next.servo_angle = angle_clamp[7:0];
    res_next.light_duty  = cur.light_on ? LIGHT_DUTY : 8'd0;
  end

  logic res_load;

  assign res_load   = (state == ST_OUT) && (!res_valid || out_ready);
  assign in_ready   = state == ST_IDLE;
  assign out_valid  = res_valid;
  assign out_result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      res_valid         <= 1'b0;
      front_step_limit  <= MOTOR_STEPS;
      back_step_limit   <= MOTOR_STEPS;
      front_speed_scale <= SPEED_PER_STEP_RST;
      back_speed_scale  <= SPEED_PER_STEP_RST;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= (cur.kind == KIND_DIST) ? ST_SCALE : ST_OUT;
        end
        ST_SCALE: begin
          front_step_limit  <= close_front ? 8'd0 : MOTOR_STEPS;
          back_step_limit   <= close_back ? 8'd0 : MOTOR_STEPS;
          front_speed_scale <= scale_front_next;
          back_speed_scale  <= scale_back_next;
          state             <= ST_IDLE;
        end
        ST_OUT: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && in_valid) begin
      cur <= in_word;
    end
    if (state == ST_MUL) begin
      f_front     <= f_front_next;
      f_back      <= f_back_next;
      close_front <= cur.dist_front < cfg.dist_lower;
      far_front   <= cur.dist_front > cfg.dist_upper;
      close_back  <= cur.dist_back < cfg.dist_lower;
      far_back    <= cur.dist_back > cfg.dist_upper;
      step_ok     <= step_ok_next;
      duty_prod   <= {16'd0, step_eff[6:0]} * {7'd0, scale_sel};
      steer_prod  <= $signed(cur.steer_step) * $signed({1'b0, cfg.steer_per_step});
    end
    if (res_load) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ----- test/distance_limited_motor_drive_test.sv -----
// Self-checking testbench for distance_limited_motor_drive: drives range and drive
// words, predicts every output word and compares it field by field.
// Depends on dlmd_pkg and the distance_limited_motor_drive RTL only.
`timescale 1ns / 1ps

module distance_limited_motor_drive_test;
  import dlmd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_LEN    = 400;
  localparam int SETTLE      = 20;
  localparam int RANDOM_WORDS_PER_PHASE = 115;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  distance_limited_motor_drive dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register values as the block holds them, and the per-side limits that
  // range words leave behind.
  cfg_t settings = '{DIST_LOWER_RST, DIST_UPPER_RST, LIMIT_SLOPE_RST, LIMIT_OFFSET_RST,
                     SPEED_PER_STEP_RST, START_DUTY_RST, MAX_DUTY_RST,
                     STEER_PER_STEP_RST};
  logic [7:0]  front_limit = MOTOR_STEPS;
  logic [7:0]  back_limit  = MOTOR_STEPS;
  logic [15:0] front_scale = SPEED_PER_STEP_RST;
  logic [15:0] back_scale  = SPEED_PER_STEP_RST;

  word_t   queued_words[$];
  result_t due_results[$];
  word_t   on_bus;

  int sender_idle_pct    = 11;
  int receiver_stall_pct = 71;
  int hold_requests      = 0;
  int holds_done         = 0;
  int hold_left          = 0;
  int failures           = 0;
  int cycle_count        = 0;

  // Step limit and duty-per-step scale for one side from its range reading.
  function automatic void band_limits(input logic [7:0] d, output logic [7:0] lim,
                                      output logic [15:0] scale);
    longint f, p;
    if (d < settings.dist_lower) begin
      lim = 8'd0;
      scale = settings.speed_per_step;
    end else if (d > settings.dist_upper) begin
      lim = MOTOR_STEPS;
      scale = settings.speed_per_step;
    end else begin
      lim = MOTOR_STEPS;
      f = longint'(d) * longint'($signed(settings.limit_slope)) +
          longint'($signed(settings.limit_offset));
      if (f <= 0) begin
        scale = 16'd0;
      end else begin
        p = (longint'(settings.speed_per_step) * f + 128) >>> 8;
        scale = (p > 65535) ? 16'hFFFF : p[15:0];
      end
    end
  endfunction

  // Updates the side limits for a range word; for a drive word returns 1
  // with the output word the block must produce.
  function automatic bit apply_word(input word_t w, output result_t r);
    int     step, steer, total, angle;
    longint duty;
    logic [15:0] scale;
    r = '0;
    if (w.kind == KIND_DIST) begin
      band_limits(w.dist_front, front_limit, front_scale);
      band_limits(w.dist_back, back_limit, back_scale);
      return 1'b0;
    end
    step = int'($signed(w.speed_step));
    scale = settings.speed_per_step;
    if (w.failsafe_on) begin
      if (int'(w.direction ? back_limit : front_limit) < step)
        step = int'(w.direction ? back_limit : front_limit);
      scale = w.direction ? back_scale : front_scale;
    end
    r.stopped = 1'b1;
    if (step >= 1 && step <= int'(MOTOR_STEPS)) begin
      duty = longint'(settings.start_duty) + ((longint'(step) * longint'(scale) + 128) >>> 8);
      if (duty <= longint'(settings.max_duty) && duty >= longint'(settings.start_duty)) begin
        r.motor_duty = duty[7:0];
        r.stopped = 1'b0;
        r.drive_fwd = !w.direction;
        r.drive_rev = w.direction;
      end
    end
    steer = int'($signed(w.steer_step));
    if (steer > int'(STEER_STEPS) || steer < -int'(STEER_STEPS))
      steer = 0;
    total = int'(SERVO_MIDDLE) * 256 + steer * int'(settings.steer_per_step);
    // Round half away from zero.
    angle = (total >= 0) ? ((total + 128) >>> 8) : -((-total + 128) >>> 8);
    if (angle > int'(SERVO_MAX))
      angle = int'(SERVO_MAX);
    if (angle < int'(SERVO_MIN))
      angle = int'(SERVO_MIN);
    r.servo_angle = angle[7:0];
    r.light_duty = w.light_on ? LIGHT_DUTY : 8'd0;
    return 1'b1;
  endfunction

  function automatic word_t word_of(item_kind_t kind, logic [7:0] front, logic [7:0] back,
                                    logic dir, int speed, int steer, logic light, logic fs);
    word_t w;
    w.kind = kind;
    w.dist_front = front;
    w.dist_back = back;
    w.direction = dir;
    w.speed_step = speed[7:0];
    w.steer_step = steer[7:0];
    w.light_on = light;
    w.failsafe_on = fs;
    return w;
  endfunction

  // Readings cluster around the thresholds; steps mostly around the valid range.
  function automatic logic [7:0] random_distance();
    int d;
    case ($urandom_range(3))
      0: d = int'(settings.dist_lower) + $urandom_range(4) - 2;
      1: d = int'(settings.dist_upper) + $urandom_range(4) - 2;
      default: d = $urandom_range(255);
    endcase
    return d[7:0];
  endfunction

  function automatic word_t random_word();
    word_t w;
    w.kind = ($urandom_range(99) < 30) ? KIND_DIST : KIND_DRIVE;
    w.dist_front = random_distance();
    w.dist_back = random_distance();
    w.direction = 1'($urandom_range(1));
    w.speed_step = ($urandom_range(99) < 80) ? 8'($urandom_range(12) - 1) : 8'($urandom);
    w.steer_step = ($urandom_range(99) < 80) ? 8'($urandom_range(24) - 12) : 8'($urandom);
    w.light_on = 1'($urandom_range(1));
    w.failsafe_on = ($urandom_range(99) < 70);
    return w;
  endfunction

  // Sender: one word on the bus at a time, refilled from the queue.
  always @(posedge clk) begin : drive_words
    word_t   nxt;
    result_t r;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (apply_word(on_bus, r))
          due_results.push_back(r);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (queued_words.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = queued_words.pop_front();
          on_bus <= nxt;
          s_axis_tdata <= {5'b0, nxt.failsafe_on, nxt.light_on, nxt.steer_step,
                           nxt.speed_step, nxt.direction, nxt.dist_back, nxt.dist_front};
          s_axis_tuser <= nxt.kind;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // Receiver: checks each output word and stalls at random or for a long hold.
  always @(posedge clk) begin : take_results
    result_t got;
    result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
        if (due_results.size() == 0) begin
          $error("output word with no expectation waiting: %h", m_axis_tdata);
          failures++;
        end else begin
          want = due_results.pop_front();
          check_field("motor_duty", want.motor_duty, got.motor_duty);
          check_field("drive_fwd", want.drive_fwd, got.drive_fwd);
          check_field("drive_rev", want.drive_rev, got.drive_rev);
          check_field("stopped", want.stopped, got.stopped);
          check_field("servo_angle", want.servo_angle, got.servo_angle);
          check_field("light_duty", want.light_duty, got.light_duty);
        end
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (holds_done != hold_requests) begin
        holds_done <= holds_done + 1;
        hold_left <= HOLD_LEN;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Range words give no output, so a final settling wait lets the last one finish.
  task automatic wait_quiet();
    do @(negedge clk);
    while (queued_words.size() > 0 || s_axis_tvalid || due_results.size() > 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
  endtask

  task automatic program_regs(cfg_t c);
    write_reg(REG_DIST_LOWER, {8'b0, c.dist_lower});
    write_reg(REG_DIST_UPPER, {8'b0, c.dist_upper});
    write_reg(REG_LIMIT_SLOPE, c.limit_slope);
    write_reg(REG_LIMIT_OFFSET, c.limit_offset);
    write_reg(REG_SPEED_PER_STEP, c.speed_per_step);
    write_reg(REG_START_DUTY, {8'b0, c.start_duty});
    write_reg(REG_MAX_DUTY, {8'b0, c.max_duty});
    write_reg(REG_STEER_PER_STEP, c.steer_per_step);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings = c;
    @(negedge clk);
  endtask

  initial begin
    cfg_t c;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words under the reset settings.
    queued_words.push_back(word_of(KIND_DRIVE, 0, 0, 0, 0, 0, 1, 0));
    queued_words.push_back(word_of(KIND_DRIVE, 0, 0, 0, 1, 0, 1, 0));
    queued_words.push_back(word_of(KIND_DRIVE, 0, 0, 1, 10, 10, 0, 0));
    queued_words.push_back(word_of(KIND_DRIVE, 0, 0, 0, 11, -10, 1, 0));
    queued_words.push_back(word_of(KIND_DRIVE, 0, 0, 0, -128, -128, 0, 0));
    queued_words.push_back(word_of(KIND_DRIVE, 255, 255, 1, 127, 127, 1, 0));
    queued_words.push_back(word_of(KIND_DRIVE, 0, 0, 0, 5, 11, 0, 0));
    queued_words.push_back(word_of(KIND_DRIVE, 0, 0, 1, 5, -11, 1, 0));
    // Front too close, back far away.
    queued_words.push_back(word_of(KIND_DIST, 0, 255, 1, 127, 127, 1, 1));
    queued_words.push_back(word_of(KIND_DRIVE, 0, 0, 0, 5, 3, 1, 1));
    queued_words.push_back(word_of(KIND_DRIVE, 0, 0, 1, 5, -3, 1, 1));
    // Readings exactly on the thresholds fall inside the limited band.
    queued_words.push_back(word_of(KIND_DIST, 20, 80, 0, 0, 0, 0, 0));
    queued_words.push_back(word_of(KIND_DRIVE, 0, 0, 0, 10, 1, 0, 1));
    queued_words.push_back(word_of(KIND_DRIVE, 0, 0, 1, 10, -1, 0, 1));
    queued_words.push_back(word_of(KIND_DIST, 19, 81, 0, 0, 0, 0, 0));
    queued_words.push_back(word_of(KIND_DRIVE, 0, 0, 0, -1, 2, 1, 1));
    queued_words.push_back(word_of(KIND_DRIVE, 0, 0, 1, 127, -2, 1, 1));
    queued_words.push_back(word_of(KIND_DRIVE, 0, 0, 1, 3, 0, 0, 1));
    wait_quiet();

    for (int phase = 1; phase <= 6; phase++) begin
      sender_idle_pct = (phase <= 2) ? 11 : (phase <= 4) ? 71 : 0;
      receiver_stall_pct = (phase <= 2) ? 71 : (phase <= 4) ? 11 : 0;
      case (phase)
        1: c = '{8'd30, 8'd100, 16'sd2, 16'sd64, 16'd3000, 8'd60, 8'd150, 16'd1500};
        // Largest values: the band scale saturates and the servo clamps.
        2: c = '{8'd0, 8'd255, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 8'd0, 8'd255, 16'hFFFF};
        // Crossed thresholds, most negative slope and offset, zero scale.
        3: c = '{8'd200, 8'd50, 16'sh8000, 16'sh8000, 16'd0, 8'd255, 8'd255, 16'd0};
        4: begin
          c.dist_lower = 8'($urandom_range(60));
          c.dist_upper = 8'($urandom_range(200, 40));
          c.limit_slope = 16'($urandom_range(600) - 100);
          c.limit_offset = 16'($urandom_range(4000) - 1000);
          c.speed_per_step = 16'($urandom_range(8000, 256));
          c.start_duty = 8'($urandom_range(150));
          c.max_duty = 8'($urandom_range(255, 100));
          c.steer_per_step = 16'($urandom_range(6000));
        end
        // Zero duty range: only a step that rounds to no increase may run.
        5: c = '{8'd10, 8'd60, -16'sd100, 16'sd8000, 16'd100, 8'd0, 8'd0, 16'd100};
        default: c = cfg_t'({$urandom, $urandom, $urandom});
      endcase
      program_regs(c);
      for (int i = 0; i < RANDOM_WORDS_PER_PHASE; i++)
        queued_words.push_back(random_word());
      // Long receiver hold while the sender keeps offering words.
      if (phase == 5)
        hold_requests++;
      wait_quiet();
    end

    if (failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
